// ===== rtl/wbpc_pkg.sv =====
package wbpc_pkg;

	// element ids and field codes
	localparam logic [7:0] RSN_ELEMENT_ID    = 8'h30;
	localparam logic [7:0] VENDOR_ELEMENT_ID = 8'hDD;
	localparam logic [7:0] WPA_OUI_TYPE      = 8'h01;

	// group cipher type codes
	localparam logic [7:0] CIPHER_WEP40  = 8'd1;
	localparam logic [7:0] CIPHER_TKIP   = 8'd2;
	localparam logic [7:0] CIPHER_CCMP   = 8'd4;
	localparam logic [7:0] CIPHER_WEP104 = 8'd5;

	// privacy class codes
	localparam logic [2:0] CLS_NONE        = 3'd0;
	localparam logic [2:0] CLS_CIPHER1     = 3'd1;
	localparam logic [2:0] CLS_CIPHER5     = 3'd2;
	localparam logic [2:0] CLS_WPA_CIPHER2 = 3'd3;
	localparam logic [2:0] CLS_RSN_CIPHER4 = 3'd4;
	localparam logic [2:0] CLS_WPA_CIPHER4 = 3'd5;
	localparam logic [2:0] CLS_RSN_CIPHER2 = 3'd6;
	localparam logic [2:0] CLS_PRIV_ONLY   = 3'd7;

	// class source codes
	localparam logic [1:0] SRC_NONE = 2'd0;
	localparam logic [1:0] SRC_RSN  = 2'd1;
	localparam logic [1:0] SRC_WPA  = 2'd2;
	localparam logic [1:0] SRC_CAP  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_RSN_CIPHER_OUI = 2'd0;
	localparam logic [1:0] CFG_WPA_VENDOR_OUI = 2'd1;
	localparam logic [1:0] CFG_WPA_CIPHER_OUI = 2'd2;

	localparam logic [23:0] RSN_CIPHER_OUI_RST = 24'h000FAC;
	localparam logic [23:0] WPA_VENDOR_OUI_RST = 24'h0050F2;
	localparam logic [23:0] WPA_CIPHER_OUI_RST = 24'h0050F2;

	typedef struct packed {
		logic [23:0] rsn_cipher_oui;
		logic [23:0] wpa_vendor_oui;
		logic [23:0] wpa_cipher_oui;
	} cfg_t;

	typedef struct packed {
		logic [2:0] privacy_class;
		logic [1:0] class_source;
	} res_t;

	// byte of an oui, first byte most significant
	function automatic logic [7:0] oui_byte(input logic [23:0] oui, input logic [1:0] pos);
		logic [7:0] b;
		case (pos)
			2'd0:    b = oui[23:16];
			2'd1:    b = oui[15:8];
			default: b = oui[7:0];
		endcase
		return b;
	endfunction

	function automatic logic [2:0] rsn_map(input logic [7:0] t);
		logic [2:0] c;
		case (t)
			CIPHER_WEP40:  c = CLS_CIPHER1;
			CIPHER_TKIP:   c = CLS_RSN_CIPHER2;
			CIPHER_CCMP:   c = CLS_RSN_CIPHER4;
			CIPHER_WEP104: c = CLS_CIPHER5;
			default:       c = CLS_NONE;
		endcase
		return c;
	endfunction

	function automatic logic [2:0] wpa_map(input logic [7:0] t);
		logic [2:0] c;
		case (t)
			CIPHER_WEP40:  c = CLS_CIPHER1;
			CIPHER_TKIP:   c = CLS_WPA_CIPHER2;
			CIPHER_CCMP:   c = CLS_WPA_CIPHER4;
			CIPHER_WEP104: c = CLS_CIPHER5;
			default:       c = CLS_NONE;
		endcase
		return c;
	endfunction

endpackage

// ===== rtl/wbpc_cfg_regs.sv =====
module wbpc_cfg_regs (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [1:0]        cfg_index,
	input  logic [23:0]       cfg_data,
	output wbpc_pkg::cfg_t    cfg
);

	// register file, writes to unused indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.rsn_cipher_oui <= wbpc_pkg::RSN_CIPHER_OUI_RST;
			cfg.wpa_vendor_oui <= wbpc_pkg::WPA_VENDOR_OUI_RST;
			cfg.wpa_cipher_oui <= wbpc_pkg::WPA_CIPHER_OUI_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				wbpc_pkg::CFG_RSN_CIPHER_OUI: cfg.rsn_cipher_oui <= cfg_data;
				wbpc_pkg::CFG_WPA_VENDOR_OUI: cfg.wpa_vendor_oui <= cfg_data;
				wbpc_pkg::CFG_WPA_CIPHER_OUI: cfg.wpa_cipher_oui <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/wbpc_parser.sv =====
module wbpc_parser (
	input  logic              clk,
	input  logic              arst_n,
	input  wbpc_pkg::cfg_t    cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        ie_byte,
	input  logic              byte_valid,
	input  logic              last_byte,
	input  logic              privacy_bit,
	output logic              res_valid,
	input  logic              res_ready,
	output wbpc_pkg::res_t    res
);

	typedef enum logic [1:0] {PH_ID, PH_LEN, PH_BODY} phase_t;
	typedef enum logic [1:0] {KIND_NONE, KIND_RSN, KIND_WPA} kind_t;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       bval_s1;
	logic       last_s1;
	logic       priv_s1;

	// parse state
	phase_t     phase_q, phase_n;
	kind_t      kind_q, kind_n;
	logic [7:0] elem_id_q, elem_id_n;
	logic [7:0] remain_q, remain_n;
	logic [3:0] idx_q, idx_n;
	logic       match_q, match_n;
	logic       rsn_checked_q, rsn_checked_n;
	logic [2:0] rsn_class_q, rsn_class_n;
	logic       wpa_checked_q, wpa_checked_n;
	logic [2:0] wpa_class_q, wpa_class_n;
	logic       advance;
	logic       wpa_type_ok;

	// a final word waits only when the result slot is full
	assign advance   = valid_s1 && (!last_s1 || res_ready);
	assign in_ready  = !valid_s1 || advance;
	assign res_valid = advance && last_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= ie_byte;
			bval_s1 <= byte_valid;
			last_s1 <= last_byte;
			priv_s1 <= privacy_bit;
		end
	end

	// next parse state for the word in the input register
	always_comb begin
		phase_n       = phase_q;
		kind_n        = kind_q;
		elem_id_n     = elem_id_q;
		remain_n      = remain_q;
		idx_n         = idx_q;
		match_n       = match_q;
		rsn_checked_n = rsn_checked_q;
		rsn_class_n   = rsn_class_q;
		wpa_checked_n = wpa_checked_q;
		wpa_class_n   = wpa_class_q;
		wpa_type_ok   = match_q && (byte_s1 == wbpc_pkg::WPA_OUI_TYPE);
		if (bval_s1) begin
			unique case (phase_q)
				PH_LEN: begin
					remain_n = byte_s1;
					idx_n    = 4'd0;
					match_n  = 1'b1;
					kind_n   = KIND_NONE;
					if (elem_id_q == wbpc_pkg::RSN_ELEMENT_ID && !rsn_checked_q) begin
						kind_n        = KIND_RSN;
						rsn_checked_n = 1'b1;
					end else if (elem_id_q == wbpc_pkg::VENDOR_ELEMENT_ID && !wpa_checked_q) begin
						kind_n = KIND_WPA;
					end
					phase_n = (byte_s1 == 8'd0) ? PH_ID : PH_BODY;
				end
				PH_BODY: begin
					if (kind_q == KIND_RSN) begin
						if (idx_q >= 4'd2 && idx_q <= 4'd4) begin
							if (byte_s1 != wbpc_pkg::oui_byte(cfg.rsn_cipher_oui,
									2'(idx_q - 4'd2)))
								match_n = 1'b0;
						end else if (idx_q == 4'd5) begin
							rsn_class_n = match_q ? wbpc_pkg::rsn_map(byte_s1)
								: wbpc_pkg::CLS_NONE;
						end
					end else if (kind_q == KIND_WPA) begin
						if (idx_q <= 4'd2) begin
							if (byte_s1 != wbpc_pkg::oui_byte(cfg.wpa_vendor_oui, idx_q[1:0]))
								match_n = 1'b0;
						end else if (idx_q == 4'd3) begin
							match_n = wpa_type_ok;
							if (wpa_type_ok)
								wpa_checked_n = 1'b1;
						end else if (idx_q >= 4'd6 && idx_q <= 4'd8) begin
							if (byte_s1 != wbpc_pkg::oui_byte(cfg.wpa_cipher_oui,
									2'(idx_q - 4'd6)))
								match_n = 1'b0;
						end else if (idx_q == 4'd9) begin
							if (wpa_checked_q)
								wpa_class_n = match_q ? wbpc_pkg::wpa_map(byte_s1)
									: wbpc_pkg::CLS_NONE;
						end
					end
					if (idx_q != 4'd15)
						idx_n = idx_q + 4'd1;
					remain_n = remain_q - 8'd1;
					if (remain_q == 8'd1)
						phase_n = PH_ID;
				end
				default: begin
					elem_id_n = byte_s1;
					phase_n   = PH_LEN;
				end
			endcase
		end
	end

	// result by precedence: rsn, then wpa, then the capability bit
	always_comb begin
		if (rsn_class_n != wbpc_pkg::CLS_NONE) begin
			res.privacy_class = rsn_class_n;
			res.class_source  = wbpc_pkg::SRC_RSN;
		end else if (wpa_class_n != wbpc_pkg::CLS_NONE) begin
			res.privacy_class = wpa_class_n;
			res.class_source  = wbpc_pkg::SRC_WPA;
		end else if (priv_s1) begin
			res.privacy_class = wbpc_pkg::CLS_PRIV_ONLY;
			res.class_source  = wbpc_pkg::SRC_CAP;
		end else begin
			res.privacy_class = wbpc_pkg::CLS_NONE;
			res.class_source  = wbpc_pkg::SRC_NONE;
		end
	end

	// parse state, cleared after the final word of a beacon
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_ID;
			kind_q        <= KIND_NONE;
			elem_id_q     <= 8'd0;
			remain_q      <= 8'd0;
			idx_q         <= 4'd0;
			match_q       <= 1'b1;
			rsn_checked_q <= 1'b0;
			rsn_class_q   <= wbpc_pkg::CLS_NONE;
			wpa_checked_q <= 1'b0;
			wpa_class_q   <= wbpc_pkg::CLS_NONE;
		end else if (advance) begin
			if (last_s1) begin
				phase_q       <= PH_ID;
				kind_q        <= KIND_NONE;
				elem_id_q     <= 8'd0;
				remain_q      <= 8'd0;
				idx_q         <= 4'd0;
				match_q       <= 1'b1;
				rsn_checked_q <= 1'b0;
				rsn_class_q   <= wbpc_pkg::CLS_NONE;
				wpa_checked_q <= 1'b0;
				wpa_class_q   <= wbpc_pkg::CLS_NONE;
			end else begin
				phase_q       <= phase_n;
				kind_q        <= kind_n;
				elem_id_q     <= elem_id_n;
				remain_q      <= remain_n;
				idx_q         <= idx_n;
				match_q       <= match_n;
				rsn_checked_q <= rsn_checked_n;
				rsn_class_q   <= rsn_class_n;
				wpa_checked_q <= wpa_checked_n;
				wpa_class_q   <= wpa_class_n;
			end
		end
	end

	// body phase always has bytes left
	a_body_remain: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_BODY |-> remain_q != 8'd0)
		else $error("body phase with no bytes remaining");

	// a class can only come from an element that was checked
	a_rsn_checked: assert property (@(posedge clk) disable iff (!arst_n)
		rsn_class_q != wbpc_pkg::CLS_NONE |-> rsn_checked_q)
		else $error("rsn class without checked rsn element");

	a_wpa_checked: assert property (@(posedge clk) disable iff (!arst_n)
		wpa_class_q != wbpc_pkg::CLS_NONE |-> wpa_checked_q)
		else $error("wpa class without checked wpa element");

	// parse state is back to idle after a result
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> phase_q == PH_ID && !rsn_checked_q && !wpa_checked_q)
		else $error("parse state not cleared after result");

endmodule

// ===== rtl/wbpc_out_reg.sv =====
module wbpc_out_reg (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	output logic              res_ready,
	input  wbpc_pkg::res_t    res,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [2:0]        privacy_class,
	output logic [1:0]        class_source
);

	logic           out_valid_q;
	wbpc_pkg::res_t res_q;

	assign res_ready     = !out_valid_q || out_ready;
	assign out_valid     = out_valid_q;
	assign privacy_class = res_q.privacy_class;
	assign class_source  = res_q.class_source;

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ===== rtl/wlan_beacon_privacy_classifier.sv =====
// Beacon privacy classifier: takes the information-element bytes of one beacon,
// one word per cycle, and on the word marked last_byte gives one result word with
// the privacy class and its source (first RSN element, then the WPA vendor
// element, then the capability privacy bit). Words that are not the last give no
// result. Throughput is one word per cycle except while a final word stalls; a
// word passes an input register and the per-byte parse logic, and the result of
// the last word is held in a result register until taken. Only a final word
// stalls, and only while that result register still holds an untaken result.
// OUI registers are written through cfg_we / cfg_index / cfg_data; the user must
// write them only while the block is idle; the block does not enforce this. Index
// 0..2 picks rsn_cipher_oui, wpa_vendor_oui, wpa_cipher_oui; others are ignored.
module wlan_beacon_privacy_classifier (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  ie_byte,
	input  logic        byte_valid,
	input  logic        last_byte,
	input  logic        privacy_bit,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  privacy_class,
	output logic [1:0]  class_source
);

	wbpc_pkg::cfg_t cfg;
	wbpc_pkg::res_t res;
	logic           res_valid;
	logic           res_ready;

	// configuration registers
	wbpc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// element parser
	wbpc_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.ie_byte     (ie_byte),
		.byte_valid  (byte_valid),
		.last_byte   (last_byte),
		.privacy_bit (privacy_bit),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res)
	);

	// result register
	wbpc_out_reg u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res           (res),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.privacy_class (privacy_class),
		.class_source  (class_source)
	);

endmodule
